FILE: src/lba_pkg.sv
package lba_pkg;

    localparam logic       OP_ALLOC     = 1'b0;
    localparam logic       OP_FREE      = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_ZERO    = 2'd2;

    localparam logic [1:0] REG_BPB_ADDR = 2'd0;
    localparam logic [15:0] BPB_RESET   = 16'd512;

    localparam int FIRST_USABLE = 2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_MUL,
        ST_ALLOC_CMP,
        ST_SCAN,
        ST_FIN,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        op;
        logic [23:0] file_size;
        logic [11:0] chain_head;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] head_block;
        logic [12:0] block_count;
        logic [11:0] free_blocks;
    } t_result;

endpackage

FILE: src/lba_ram.sv
module lba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lba_engine.sv
module lba_engine #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lba_pkg::t_req    i_req,
    input  logic [15:0]      i_bpb,
    output logic             o_ready,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output lba_pkg::t_result o_res
);
    import lba_pkg::*;

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int CW = IW + 1;
    localparam int LW = IW + 1;
    localparam int MW = LW + 1;
    localparam int PW = (CW + 16 > 24) ? CW + 16 : 25;
    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_BLOCKS);
    localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_BLOCKS - 1);
    localparam logic [IW:0]   END_ADDR  = (IW + 1)'(NUM_BLOCKS);
    localparam logic [LW-1:0] FIRST_LNK = LW'(FIRST_USABLE);
    localparam logic [CW-1:0] FREE_INIT = CW'(NUM_BLOCKS - 2);

    t_state        r_state, n_state;
    logic [IW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_free, n_free;
    logic [23:0]   r_size, n_size;
    logic [15:0]   r_bpb, n_bpb;
    logic [PW-1:0] r_prod, n_prod;
    logic [IW:0]   r_raddr, n_raddr;
    logic [IW-1:0] r_daddr, n_daddr;
    logic          r_dvalid, n_dvalid;
    logic [CW-1:0] r_got, n_got;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_prev, n_prev;
    logic [IW-1:0] r_cur, n_cur;
    t_result       r_res, n_res;

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata, mem_rdata;
    logic          rd_occ;
    logic [LW-1:0] rd_link;
    logic          found, last, head_ok, link_ok;
    logic [CW-1:0] cnt_new;

    lba_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_occ  = mem_rdata[MW-1];
    assign rd_link = mem_rdata[LW-1:0];
    assign found   = r_dvalid && !rd_occ;
    assign last    = r_size <= {8'd0, r_bpb};
    assign head_ok = (i_req.chain_head >= 12'(FIRST_USABLE))
                  && ({5'd0, i_req.chain_head} < 17'(NUM_BLOCKS));
    assign link_ok = (rd_link >= FIRST_LNK) && (rd_link < NULL_LINK);
    assign cnt_new = rd_occ ? r_got + CW'(1) : r_got;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_free   <= FREE_INIT;
            r_dvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_free   <= n_free;
            r_dvalid <= n_dvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_bpb   <= n_bpb;
        r_prod  <= n_prod;
        r_raddr <= n_raddr;
        r_daddr <= n_daddr;
        r_got   <= n_got;
        r_head  <= n_head;
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_res   <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_free      = r_free;
        n_size      = r_size;
        n_bpb       = r_bpb;
        n_prod      = r_prod;
        n_raddr     = r_raddr;
        n_daddr     = r_daddr;
        n_dvalid    = r_dvalid;
        n_got       = r_got;
        n_head      = r_head;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = {1'b0, NULL_LINK};
                n_clr     = r_clr + IW'(1);
                if (r_clr == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_got = '0;
                    if (i_req.op == OP_ALLOC) begin
                        n_size = i_req.file_size;
                        n_bpb  = (i_bpb == 16'd0) ? 16'd1 : i_bpb;
                        if (i_req.file_size == 24'd0) begin
                            n_res   = '{STAT_ZERO, 12'd0, 13'd0, 12'(r_free)};
                            n_state = ST_OUT;
                        end else begin
                            n_state = ST_ALLOC_MUL;
                        end
                    end else begin
                        n_res.status     = STAT_OK;
                        n_res.head_block = i_req.chain_head;
                        if (head_ok) begin
                            n_cur   = IW'(i_req.chain_head);
                            n_state = ST_FREE_RD;
                        end else begin
                            n_res.block_count = 13'd0;
                            n_res.free_blocks = 12'(r_free);
                            n_state           = ST_OUT;
                        end
                    end
                end
            end
            ST_ALLOC_MUL: begin
                n_prod  = PW'(r_free) * PW'(r_bpb);
                n_state = ST_ALLOC_CMP;
            end
            ST_ALLOC_CMP: begin
                if (r_prod < PW'(r_size)) begin
                    n_res   = '{STAT_NOSPACE, 12'd0, 13'd0, 12'(r_free)};
                    n_state = ST_OUT;
                end else begin
                    n_raddr  = (IW + 1)'(FIRST_USABLE);
                    n_dvalid = 1'b0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // reads run one ahead of the returned data
                if (!(found && last) && (r_raddr < END_ADDR)) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_raddr[IW-1:0];
                    n_raddr   = r_raddr + (IW + 1)'(1);
                    n_daddr   = r_raddr[IW-1:0];
                    n_dvalid  = 1'b1;
                end else begin
                    n_dvalid = 1'b0;
                end
                if (found) begin
                    if (r_got == '0) begin
                        n_head = r_daddr;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_prev;
                        mem_wdata = {1'b1, LW'(r_daddr)};
                    end
                    n_prev = r_daddr;
                    n_got  = r_got + CW'(1);
                    if (last) begin
                        n_state = ST_FIN;
                    end else begin
                        n_size = r_size - 24'(r_bpb);
                    end
                end else if (!r_dvalid && (r_raddr == END_ADDR)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // tail of the new chain
                mem_we    = 1'b1;
                mem_waddr = r_prev;
                mem_wdata = {1'b1, NULL_LINK};
                n_free    = r_free - r_got;
                n_res     = '{STAT_OK, 12'(r_head), 13'(r_got), 12'(r_free - r_got)};
                n_state   = ST_OUT;
            end
            ST_FREE_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_cur;
                n_state   = ST_FREE_CHK;
            end
            ST_FREE_CHK: begin
                if (rd_occ) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = {1'b0, NULL_LINK};
                    n_got     = cnt_new;
                end
                if (rd_occ && link_ok) begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_link[IW-1:0];
                    n_cur     = rd_link[IW-1:0];
                end else begin
                    n_free            = r_free + cnt_new;
                    n_res.block_count = 13'(cnt_new);
                    n_res.free_blocks = 12'(r_free + cnt_new);
                    n_state           = ST_OUT;
                end
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FREE_INIT)
        else $error("free count above usable blocks");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same entry");

    a_fin_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (r_got != '0))
        else $error("allocation finished with no blocks");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_res.status == STAT_OK && r_res.block_count != 13'd0))
        else $error("allocation result lost its count");

endmodule

FILE: src/linked_block_allocator.sv
// First-fit block allocator with linked chains. After reset a clearing pass
// initializes the block table; no item is taken meanwhile, register writes
// are. Allocate converts file_size into blocks of bytes_per_block (0 counts
// as 1), checks the free count, then scans the table from block 2 one entry
// per cycle. Free walks the chain one block per cycle. Both rates are set by
// the single-port read path of the block table. A result waits in an output
// register, so the next item is taken while it is pending.
module linked_block_allocator #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // file_size[23:0], chain_head[35:24], zero pad
    input  logic [0:0]  s_axis_tuser,  // operation[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // head_block[11:0], block_count[24:12],
                                       // free_blocks[36:25], zero pad
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lba_pkg::*;

    logic        r_bpb_valid;
    logic [15:0] r_bpb;
    logic        r_m_valid;
    t_result     r_m_res;
    logic        eng_ready, res_valid, res_ready;
    t_req        req;
    t_result     res;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_BPB_ADDR);
    assign prdata = (paddr == REG_BPB_ADDR) ? {16'd0, r_bpb} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpb       <= BPB_RESET;
            r_bpb_valid <= 1'b0;
        end else begin
            r_bpb_valid <= 1'b1;
            if (cfg_wr) begin
                r_bpb <= pwdata[15:0];
            end
        end
    end

    assign req.op         = s_axis_tuser[0];
    assign req.file_size  = s_axis_tdata[23:0];
    assign req.chain_head = s_axis_tdata[35:24];

    assign s_axis_tready = eng_ready && r_bpb_valid;
    assign res_ready     = !r_m_valid || m_axis_tready;

    lba_engine #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid && s_axis_tready),
        .i_req       (req),
        .i_bpb       (r_bpb),
        .o_ready     (eng_ready),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tdata  = {3'd0, r_m_res.free_blocks, r_m_res.block_count,
                            r_m_res.head_block};

endmodule
